### rtl/core/bar_pkg.sv
// ----------------------------------------------------------------------------
// bar_pkg: shared types and constants for the button auto-repeat controller
// Register indexes, reset values, field widths and the structs that pass
// between the sequencer, the bit scanner and the output register.
// ----------------------------------------------------------------------------
package bar_pkg;

    localparam int NUM_BUTTONS_DEF = 10;

    localparam int CODE_W  = 4;
    localparam int CNT_W   = 16;
    localparam int RMASK_W = 10;
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0]   DELAY_RST  = 16'd500;
    localparam logic [CNT_W-1:0]   PERIOD_RST = 16'd30;
    localparam logic [RMASK_W-1:0] RMASK_RST  = 10'd60;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY  = 2'd0,
        REG_PERIOD = 2'd1,
        REG_RMASK  = 2'd2,
        REG_ENABLE = 2'd3
    } cfg_idx_t;

    // Input kinds carried on s_tuser
    localparam logic CMD_BUTTON = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Sequencer to scanner
    typedef struct packed {
        logic load;
        logic shift;
    } scan_ctrl_t;

    // Scanner to sequencer
    typedef struct packed {
        logic              bit_set;
        logic              last;
        logic [CODE_W-1:0] code;
    } scan_stat_t;

    // One result word
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic               is_down;
        logic [CODE_W-1:0]  code;
        logic               last;
    } out_word_t;

endpackage

### rtl/core/bar_scan.sv
// ----------------------------------------------------------------------------
// bar_scan: held-button scanner
// Shift register walking the repeat set one button per cycle while shift is asserted, lowest first.
// ----------------------------------------------------------------------------
module bar_scan import bar_pkg::*; #(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic                   aclk,
    input  logic [NUM_BUTTONS-1:0] load_mask,
    input  scan_ctrl_t             ctrl,
    output scan_stat_t             stat
);
    localparam int IDX_W = $clog2(NUM_BUTTONS);

    logic [NUM_BUTTONS-1:0]  work_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W+CODE_W-1:0] idx_ext;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            work_reg <= load_mask;
            idx_reg  <= '0;
        end else if (ctrl.shift) begin
            work_reg <= work_reg >> 1;
            idx_reg  <= idx_reg + IDX_W'(1);
        end
    end

    assign idx_ext      = {{CODE_W{1'b0}}, idx_reg};
    assign stat.code    = idx_ext[CODE_W-1:0];
    assign stat.bit_set = work_reg[0];
    // no set bit above the current one
    assign stat.last    = (work_reg[NUM_BUTTONS-1:1] == '0);

endmodule

### rtl/core/bar_out_reg.sv
// ----------------------------------------------------------------------------
// bar_out_reg: result output register
// Holds one word for the master side until it is taken.
// ----------------------------------------------------------------------------
module bar_out_reg import bar_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  out_word_t word_in,
    output logic      slot_free,
    output logic      m_tvalid,
    input  logic      m_tready,
    output logic [39:0] m_tdata,
    output logic      m_tlast
);
    logic      valid_reg;
    out_word_t word_reg;

    assign slot_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (load) begin
            word_reg <= word_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, word_reg.stamp, word_reg.is_down, word_reg.code};
    assign m_tlast  = word_reg.last;

endmodule

### rtl/core/button_auto_repeat_controller.sv
// ----------------------------------------------------------------------------
// button_auto_repeat_controller: typematic auto-repeat for a button pad
// Tracks held buttons and a tick clock; emits down/up words for button
// events and repeated down words for held repeatable buttons on expiry.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake          | content
//  ----------+-----+--------------------+-----------------------------------
//  s_        | in  | s_tvalid/s_tready  | tuser command, tdata button,pressed
//  m_        | out | m_tvalid/m_tready  | tdata code,is_down,stamp; tlast
//  cfg_      | in  | cfg_wr_en          | delay, period, repeat mask, enable
//
//  Button event: accepted in ST_IDLE; its word loads the output register
//  from ST_SEND once the output slot is free.
//  Tick with expiry: the scan shifter walks the bit positions in turn up to
//  the highest held repeatable button (at most NUM_BUTTONS); a set bit
//  waits for a free output slot. Other ticks and ignored events stay in ST_IDLE.
//  Reset (aresetn low, synchronous) clears mask, countdown, tick clock,
//  output valid and returns registers to 500 / 30 / 0x3C / disabled.
//  m_tready low holds the sequencer on its pending word; s_tready is high
//  only while the sequencer is idle.
//
module button_auto_repeat_controller import bar_pkg::*; #(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [3:0] button, [4] pressed
    input  logic                 s_tuser,   // [0] command (0 button, 1 tick)
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // [3:0] event_button, [4] is_down,
                                            // [36:5] time_stamp
    output logic                 m_tlast,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEND,
        ST_SCAN
    } state_t;

    localparam logic [5:0] NB = 6'(NUM_BUTTONS);

    // configuration registers
    logic [CNT_W-1:0]   delay_reg;
    logic [CNT_W-1:0]   period_reg;
    logic [RMASK_W-1:0] rmask_reg;
    logic               enable_reg;

    // block state
    state_t                 state_reg, state_next;
    logic [NUM_BUTTONS-1:0] held_reg, held_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   running_reg, running_next;
    logic [STAMP_W-1:0]     tick_reg, tick_next;
    logic [CODE_W-1:0]      pend_code_reg, pend_code_next;
    logic                   pend_down_reg, pend_down_next;

    logic [CODE_W-1:0]      in_button;
    logic                   in_pressed;
    logic                   accept;
    logic [NUM_BUTTONS-1:0] btn_bit;
    logic [NUM_BUTTONS-1:0] held_upd;   // mask after the offered button event
    logic [NUM_BUTTONS+RMASK_W-1:0] rmask_ext;
    logic [NUM_BUTTONS-1:0] rmask_nb;
    logic [NUM_BUTTONS-1:0] send_now;   // repeat set from the current mask
    logic [NUM_BUTTONS-1:0] send_new;   // repeat set after a button event

    scan_ctrl_t scan_ctrl;
    scan_stat_t scan_stat;
    logic       out_load;
    logic       slot_free;
    out_word_t  out_word;

    assign in_button  = s_tdata[3:0];
    assign in_pressed = s_tdata[4];
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;

    assign btn_bit   = NUM_BUTTONS'(1) << in_button;
    assign held_upd  = in_pressed ? (held_reg | btn_bit) : (held_reg & ~btn_bit);
    assign rmask_ext = {{NUM_BUTTONS{1'b0}}, rmask_reg};
    assign rmask_nb  = rmask_ext[NUM_BUTTONS-1:0];
    assign send_now  = held_reg & rmask_nb;
    assign send_new  = held_upd & rmask_nb;

    always_comb begin
        state_next     = state_reg;
        held_next      = held_reg;
        count_next     = count_reg;
        running_next   = running_reg;
        tick_next      = tick_reg;
        pend_code_next = pend_code_reg;
        pend_down_next = pend_down_reg;
        scan_ctrl      = '0;
        out_load       = 1'b0;
        out_word       = '0;
        out_word.stamp = tick_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser == CMD_BUTTON) begin
                    if (enable_reg && ({2'b00, in_button} < NB)) begin
                        held_next      = held_upd;
                        pend_code_next = in_button;
                        pend_down_next = in_pressed;
                        state_next     = ST_SEND;
                        // arm or stop the countdown
                        if (send_new != '0) begin
                            count_next   = (delay_reg == '0) ? CNT_W'(1) : delay_reg;
                            running_next = 1'b1;
                        end else begin
                            count_next   = '0;
                            running_next = 1'b0;
                        end
                    end
                end else if (accept) begin
                    tick_next = tick_reg + STAMP_W'(1);
                    if (enable_reg && running_reg) begin
                        if (count_reg > CNT_W'(1)) begin
                            count_next = count_reg - CNT_W'(1);
                        end else if (send_now == '0) begin
                            count_next   = '0;
                            running_next = 1'b0;
                        end else begin
                            // expiry: reload period and walk the repeat set
                            count_next = (period_reg == '0) ? CNT_W'(1) : period_reg;
                            scan_ctrl.load = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                end
            end
            ST_SEND: begin
                out_word.code    = pend_code_reg;
                out_word.is_down = pend_down_reg;
                out_word.last    = 1'b1;
                if (slot_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                out_word.code    = scan_stat.code;
                out_word.is_down = 1'b1;
                out_word.last    = scan_stat.last;
                // a clear bit just shifts; a set bit waits for the output slot
                if (!scan_stat.bit_set || slot_free) begin
                    scan_ctrl.shift = 1'b1;
                    out_load        = scan_stat.bit_set;
                    if (scan_stat.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            held_reg    <= '0;
            count_reg   <= '0;
            running_reg <= 1'b0;
            tick_reg    <= '0;
            delay_reg   <= DELAY_RST;
            period_reg  <= PERIOD_RST;
            rmask_reg   <= RMASK_RST;
            enable_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            count_reg   <= count_next;
            running_reg <= running_next;
            tick_reg    <= tick_next;
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    REG_DELAY:  delay_reg  <= cfg_wdata;
                    REG_PERIOD: period_reg <= cfg_wdata;
                    REG_RMASK:  rmask_reg  <= cfg_wdata[RMASK_W-1:0];
                    REG_ENABLE: enable_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
        pend_code_reg <= pend_code_next;
        pend_down_reg <= pend_down_next;
    end

    bar_scan #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_scan (
        .aclk      (aclk),
        .load_mask (send_now),
        .ctrl      (scan_ctrl),
        .stat      (scan_stat)
    );

    bar_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .word_in   (out_word),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // a word is only produced by an active sequence
    a_no_idle_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> state_reg != ST_IDLE)
        else $error("result loaded while idle");

    // never overwrite a word still waiting on the master side
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid || m_tready))
        else $error("output word overwritten");

    // an accepted in-range button event while enabled always yields a word
    a_event_sends: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == CMD_BUTTON && enable_reg && ({2'b00, in_button} < NB))
        |=> state_reg == ST_SEND)
        else $error("button event lost");

    // a running countdown never sits at zero
    a_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> count_reg != '0)
        else $error("countdown running at zero");

    // the scan only starts with a nonempty repeat set
    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_ctrl.load |-> send_now != '0)
        else $error("scan started with nothing to repeat");

endmodule
